/* design/mrf_pkg.sv */
// shared types, constants and crc function for the modbus rtu response framer
`timescale 1ns / 1ps

package mrf_pkg;

  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [8:0]  READ_OVERHEAD   = 9'd5;
  localparam logic [8:0]  WRITE_FRAME_LEN = 9'd8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ADDR_ERR = 2'd1;
  localparam logic [1:0] ST_FUNC_ERR = 2'd2;
  localparam logic [1:0] ST_CRC_ERR  = 2'd3;

  localparam logic [7:0] FC_READ_COILS   = 8'd1;
  localparam logic [7:0] FC_READ_INPUTS  = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_READ_INPUT_R = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL   = 8'd5;
  localparam logic [7:0] FC_WRITE_REG    = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // what the back end does with one byte
  typedef enum logic [2:0] {
    OP_START,
    OP_START_REPORT,
    OP_REPORT,
    OP_DATA,
    OP_CRC_LOW,
    OP_CRC_HIGH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [1:0] status;
    logic [8:0] length;
    logic [7:0] fcode;
  } cmd_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* design/mrf_front.sv */
// front end: tracks frame position, checks address and function code, issues commands
`timescale 1ns / 1ps

module mrf_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_rx_byte,
  input  logic             in_restart,
  input  logic [7:0]       expected_address,
  input  logic             q_full,
  output logic             push,
  output mrf_pkg::cmd_t    cmd
);

  logic [8:0] idx_r, idx_nxt;
  logic [8:0] tgt_r, tgt_nxt;
  logic [7:0] fn_r, fn_nxt;

  logic [8:0] idx_c, tgt_c, tgt_eff;
  logic [7:0] fn_c;
  logic [9:0] pos_sum;
  logic       accept;
  logic       is_read, is_write;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept;

  always_comb begin
    idx_c = in_restart ? 9'd0 : idx_r;
    tgt_c = in_restart ? 9'd0 : tgt_r;
    fn_c  = in_restart ? 8'd0 : fn_r;

    is_read  = (in_rx_byte == mrf_pkg::FC_READ_COILS) || (in_rx_byte == mrf_pkg::FC_READ_INPUTS) ||
               (in_rx_byte == mrf_pkg::FC_READ_HOLDING) ||
               (in_rx_byte == mrf_pkg::FC_READ_INPUT_R);
    is_write = (in_rx_byte == mrf_pkg::FC_WRITE_COIL) || (in_rx_byte == mrf_pkg::FC_WRITE_REG) ||
               (in_rx_byte == mrf_pkg::FC_WRITE_MULTI);

    // read frames learn their length from the byte count
    tgt_eff = (tgt_c == 9'd0) ? ({1'b0, in_rx_byte} + mrf_pkg::READ_OVERHEAD) : tgt_c;
    pos_sum = {1'b0, idx_c} + 10'd2;

    idx_nxt    = idx_c;
    tgt_nxt    = tgt_c;
    fn_nxt     = fn_c;
    cmd.op     = mrf_pkg::OP_DATA;
    cmd.data   = in_rx_byte;
    cmd.status = mrf_pkg::ST_OK;
    cmd.length = 9'd0;
    cmd.fcode  = 8'd0;

    if (idx_c == 9'd0) begin
      if (in_rx_byte == expected_address) begin
        cmd.op  = mrf_pkg::OP_START;
        idx_nxt = 9'd1;
      end else begin
        cmd.op     = mrf_pkg::OP_REPORT;
        cmd.status = mrf_pkg::ST_ADDR_ERR;
        cmd.length = 9'd1;
      end
    end else if (idx_c == 9'd1) begin
      if (is_read || is_write) begin
        cmd.op  = mrf_pkg::OP_DATA;
        tgt_nxt = is_write ? mrf_pkg::WRITE_FRAME_LEN : 9'd0;
        fn_nxt  = in_rx_byte;
        idx_nxt = 9'd2;
      end else begin
        // bad function byte is retried as an address byte
        cmd.status = mrf_pkg::ST_FUNC_ERR;
        cmd.fcode  = in_rx_byte;
        tgt_nxt    = 9'd0;
        fn_nxt     = 8'd0;
        if (in_rx_byte == expected_address) begin
          cmd.op     = mrf_pkg::OP_START_REPORT;
          cmd.length = 9'd1;
          idx_nxt    = 9'd1;
        end else begin
          cmd.op     = mrf_pkg::OP_REPORT;
          cmd.length = 9'd2;
          idx_nxt    = 9'd0;
        end
      end
    end else begin
      tgt_nxt = tgt_eff;
      if (pos_sum < {1'b0, tgt_eff}) begin
        cmd.op  = mrf_pkg::OP_DATA;
        idx_nxt = idx_c + 9'd1;
      end else if (pos_sum == {1'b0, tgt_eff}) begin
        cmd.op  = mrf_pkg::OP_CRC_LOW;
        idx_nxt = idx_c + 9'd1;
      end else begin
        cmd.op     = mrf_pkg::OP_CRC_HIGH;
        cmd.length = tgt_eff;
        cmd.fcode  = fn_c;
        idx_nxt    = 9'd0;
        tgt_nxt    = 9'd0;
        fn_nxt     = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 9'd0;
      tgt_r <= 9'd0;
      fn_r  <= 8'd0;
    end else if (accept) begin
      idx_r <= idx_nxt;
      tgt_r <= tgt_nxt;
      fn_r  <= fn_nxt;
    end
  end

endmodule

/* design/mrf_queue.sv */
// short command queue between front and back end
`timescale 1ns / 1ps

module mrf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mrf_pkg::cmd_t         push_cmd,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output mrf_pkg::cmd_t         head
);

  mrf_pkg::cmd_t               mem_r [mrf_pkg::QUEUE_DEPTH];
  logic [mrf_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [mrf_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [mrf_pkg::QCNT_W-1:0]  count_r, count_nxt;

  assign full  = (count_r == mrf_pkg::QCNT_W'(mrf_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mrf_pkg::QPTR_W'(mrf_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == mrf_pkg::QPTR_W'(mrf_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* design/mrf_back.sv */
// back end: running crc, trailing crc compare and result register
`timescale 1ns / 1ps

module mrf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             empty,
  input  mrf_pkg::cmd_t    head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [8:0]       out_frame_length,
  output logic [7:0]       out_function_code
);

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        valid_r, valid_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [8:0]  len_r, len_nxt;
  logic [7:0]  fc_r, fc_nxt;
  logic        emits;

  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_frame_length  = len_r;
  assign out_function_code = fc_r;

  always_comb begin
    emits = (head.op == mrf_pkg::OP_START_REPORT) || (head.op == mrf_pkg::OP_REPORT) ||
            (head.op == mrf_pkg::OP_CRC_HIGH);
    // a result-free request never waits on the output side
    pop = !empty && (!emits || !valid_r || !out_stall);

    crc_nxt    = crc_r;
    low_nxt    = low_r;
    status_nxt = status_r;
    len_nxt    = len_r;
    fc_nxt     = fc_r;
    valid_nxt  = valid_r && out_stall;

    if (pop) begin
      unique case (head.op)
        mrf_pkg::OP_START: begin
          crc_nxt = mrf_pkg::crc_update(mrf_pkg::CRC_INIT, head.data);
        end
        mrf_pkg::OP_START_REPORT: begin
          crc_nxt    = mrf_pkg::crc_update(mrf_pkg::CRC_INIT, head.data);
          status_nxt = head.status;
          len_nxt    = head.length;
          fc_nxt     = head.fcode;
          valid_nxt  = 1'b1;
        end
        mrf_pkg::OP_REPORT: begin
          status_nxt = head.status;
          len_nxt    = head.length;
          fc_nxt     = head.fcode;
          valid_nxt  = 1'b1;
        end
        mrf_pkg::OP_DATA: begin
          crc_nxt = mrf_pkg::crc_update(crc_r, head.data);
        end
        mrf_pkg::OP_CRC_LOW: begin
          low_nxt = head.data;
        end
        mrf_pkg::OP_CRC_HIGH: begin
          status_nxt = ({head.data, low_r} == crc_r) ? mrf_pkg::ST_OK : mrf_pkg::ST_CRC_ERR;
          len_nxt    = head.length;
          fc_nxt     = head.fcode;
          valid_nxt  = 1'b1;
        end
        default: begin
          crc_nxt = crc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      crc_r   <= mrf_pkg::CRC_INIT;
      low_r   <= 8'd0;
    end else begin
      valid_r <= valid_nxt;
      crc_r   <= crc_nxt;
      low_r   <= low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    len_r    <= len_nxt;
    fc_r     <= fc_nxt;
  end

endmodule

/* design/modbus_rtu_response_framer.sv */
// modbus rtu response framer top level: address register, front end, queue, back end
// a result for the byte that completes or breaks a frame passes through a queue entry, then the result register
// throughput: one byte per cycle while in_stall is low, bounded by the bytewise crc update
// the two-entry queue lets the front keep taking bytes while a result waits on out_stall
// reset: frame position, queue and output valid clear; crc returns to 0xffff
// reset: expected address returns to 0
`timescale 1ns / 1ps

module modbus_rtu_response_framer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_restart,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [8:0] out_frame_length,
  output logic [7:0] out_function_code
);

  logic [7:0]    addr_r;
  logic          q_full, q_empty, q_push, q_pop;
  mrf_pkg::cmd_t push_cmd, head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= 8'd0;
    end else if (cfg_wr_en) begin
      addr_r <= cfg_wr_data;
    end
  end

  mrf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .in_restart       (in_restart),
    .expected_address (addr_r),
    .q_full           (q_full),
    .push             (q_push),
    .cmd              (push_cmd)
  );

  mrf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_cmd)
  );

  mrf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .empty             (q_empty),
    .head              (head_cmd),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_frame_length  (out_frame_length),
    .out_function_code (out_function_code)
  );

endmodule

/* bench/modbus_rtu_response_framer_tb.sv */
// self-checking bench for the modbus rtu response framer: bursty bytes in, stalled results out
`timescale 1ns / 1ps

module modbus_rtu_response_framer_tb;
  import mrf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PER_PHASE = 300;
  localparam int NUM_PHASES = 6;
  localparam int HOLD_CYCLES = 500;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } rx_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] length;
    logic [7:0] fcode;
  } result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_restart = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  logic [8:0] out_frame_length;
  logic [7:0] out_function_code;

  modbus_rtu_response_framer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_frame_length (out_frame_length),
    .out_function_code(out_function_code)
  );

  always #6 clk = ~clk;

  // framer model state
  logic [7:0]  slave_addr = 8'h00;
  logic [8:0]  frame_pos = 9'd0;
  logic [15:0] crc_acc = CRC_INIT;
  logic [7:0]  frame_fc = 8'h00;
  logic [8:0]  frame_len = 9'd0;
  logic [7:0]  crc_lo = 8'h00;

  rx_item_t pending_bytes[$];
  result_t  expected_results[$];

  int errors = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int items_queued = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_cyc = 0;
  int stall_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  rx_item_t nxt;
  result_t  pred;
  result_t  want;

  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] x;
    x = c;
    // bit-serial, lsb first
    for (int i = 0; i < 8; i++) begin
      x = (x[0] ^ d[i]) ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  function automatic bit is_read_fc(input logic [7:0] b);
    return b >= FC_READ_COILS && b <= FC_READ_INPUT_R;
  endfunction

  function automatic bit is_write_fc(input logic [7:0] b);
    return b == FC_WRITE_COIL || b == FC_WRITE_REG || b == FC_WRITE_MULTI;
  endfunction

  function automatic void clear_frame_state();
    frame_pos = 9'd0;
    crc_acc = CRC_INIT;
    frame_fc = 8'h00;
    frame_len = 9'd0;
    crc_lo = 8'h00;
  endfunction

  function automatic bit open_frame(input logic [7:0] b);
    clear_frame_state();
    if (b != slave_addr) return 1'b0;
    crc_acc = crc_next(CRC_INIT, b);
    frame_pos = 9'd1;
    return 1'b1;
  endfunction

  // advances the framer model by one byte; returns 1 when a result is due
  function automatic bit frame_step(input logic [7:0] b, input logic rs, output result_t r);
    logic [15:0] rx_crc;
    r = '0;
    if (rs) clear_frame_state();
    if (frame_pos == 9'd0) begin
      if (!open_frame(b)) begin
        r = '{ST_ADDR_ERR, 9'd1, 8'h00};
        return 1'b1;
      end
      return 1'b0;
    end
    if (frame_pos == 9'd1) begin
      if (is_read_fc(b)) begin
        frame_len = 9'd0;
      end else if (is_write_fc(b)) begin
        frame_len = WRITE_FRAME_LEN;
      end else begin
        // offending byte is retried as an address byte
        r.status = ST_FUNC_ERR;
        r.fcode = b;
        r.length = open_frame(b) ? 9'd1 : 9'd2;
        return 1'b1;
      end
      frame_fc = b;
      crc_acc = crc_next(crc_acc, b);
      frame_pos = 9'd2;
      return 1'b0;
    end
    if (frame_len == 9'd0) frame_len = {1'b0, b} + READ_OVERHEAD;
    if (frame_pos + 9'd2 < frame_len) begin
      crc_acc = crc_next(crc_acc, b);
      frame_pos = frame_pos + 9'd1;
      return 1'b0;
    end
    if (frame_pos + 9'd2 == frame_len) begin
      crc_lo = b;
      frame_pos = frame_pos + 9'd1;
      return 1'b0;
    end
    rx_crc = {b, crc_lo};
    r.status = (rx_crc == crc_acc) ? ST_OK : ST_CRC_ERR;
    r.length = frame_len;
    r.fcode = frame_fc;
    clear_frame_state();
    return 1'b1;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic rs);
    pending_bytes.push_back('{b, rs});
    items_queued++;
  endtask

  // builds one response; cut > 0 keeps only the first cut bytes
  task automatic queue_frame(input logic [7:0] a, input logic [7:0] fc, input int count,
                             input bit bad_crc, input bit rs_first, input int cut);
    logic [7:0]  fb[$];
    logic [15:0] c;
    fb.push_back(a);
    fb.push_back(fc);
    if (is_read_fc(fc)) begin
      fb.push_back(8'(count));
      repeat (count) fb.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (4) fb.push_back(8'($urandom_range(0, 255)));
    end
    c = CRC_INIT;
    foreach (fb[i]) c = crc_next(c, fb[i]);
    if (bad_crc) c ^= 16'($urandom_range(1, 16'hFFFF));
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    if (cut > 0 && cut < fb.size()) fb = fb[0:cut-1];
    foreach (fb[i]) push_byte(fb[i], rs_first && i == 0);
  endtask

  function automatic logic [7:0] random_fc();
    case ($urandom_range(0, 6))
      0: return FC_READ_COILS;
      1: return FC_READ_INPUTS;
      2: return FC_READ_HOLDING;
      3: return FC_READ_INPUT_R;
      4: return FC_WRITE_COIL;
      5: return FC_WRITE_REG;
      default: return FC_WRITE_MULTI;
    endcase
  endfunction

  function automatic int random_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 12);
    if (r < 98) return $urandom_range(13, 64);
    return $urandom_range(0, 1) ? 255 : $urandom_range(200, 254);
  endfunction

  task automatic report(input string what, input int exp_v, input int act_v);
    errors++;
    if (errors <= 50) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    end
  endtask

  // request driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        bytes_taken++;
        if (frame_step(in_rx_byte, in_restart, pred)) expected_results.push_back(pred);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          nxt = pending_bytes.pop_front();
          in_rx_byte <= nxt.rx_byte;
          in_restart <= nxt.restart;
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall pattern, with one long hold-off while requests are still queued
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_cyc++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 40 && pending_bytes.size() > 100) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        if (stall_cyc % 50 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= ($urandom_range(0, 9) < 8);
          default: out_stall <= (stall_cyc % 4 == 0);
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      status_seen[out_status]++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 50) begin
          $display("%0t: unexpected result, expected none, actual status %0d length %0d fc %0d",
                   $time, out_status, out_frame_length, out_function_code);
        end
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) report("status", want.status, out_status);
        if (out_frame_length !== want.length) report("frame_length", want.length,
                                                     out_frame_length);
        if (out_function_code !== want.fcode) report("function_code", want.fcode,
                                                     out_function_code);
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0] addr;
    logic [7:0] b;
    int         phase_end;
    int         pick;
    bit         need_rs;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: addr = 8'h11;
        1: addr = 8'h00;
        2: addr = 8'hFF;
        default: addr = 8'($urandom_range(0, 255));
      endcase
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= addr;
      slave_addr = addr;
      @(posedge clk);
      cfg_wr_en <= 1'b0;

      if (ph == 0) begin
        // good read frame with zero byte count
        queue_frame(addr, FC_READ_HOLDING, 0, 1'b0, 1'b0, 0);
        // address mismatches, one with restart
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        // unknown function code equal to the address opens a new frame, bad crc
        push_byte(addr, 1'b0);
        queue_frame(addr, FC_WRITE_REG, 0, 1'b1, 1'b0, 0);
        // unknown function code that is not the address
        push_byte(addr, 1'b0);
        push_byte(8'hFF, 1'b0);
        // partial frame dropped by restart
        queue_frame(addr, FC_READ_COILS, 3, 1'b0, 1'b0, 2);
        queue_frame(addr, FC_READ_INPUTS, 0, 1'b0, 1'b1, 0);
      end else begin
        phase_end = items_queued + RANDOM_PER_PHASE;
        need_rs = 1'b0;
        while (items_queued < phase_end) begin
          pick = $urandom_range(0, 99);
          if (pick < 68) begin
            queue_frame(addr, random_fc(), random_count(), 1'b0,
                        need_rs || $urandom_range(0, 9) == 0, 0);
          end else if (pick < 78) begin
            queue_frame(addr, random_fc(), random_count(), 1'b1, need_rs, 0);
          end else if (pick < 86) begin
            queue_frame(addr, random_fc(), random_count(), 1'($urandom_range(0, 1)), need_rs,
                        $urandom_range(1, 6));
          end else if (pick < 92) begin
            do begin
              b = 8'($urandom_range(0, 255));
            end while (is_read_fc(b) || is_write_fc(b));
            if ($urandom_range(0, 2) == 0 && !is_read_fc(addr) && !is_write_fc(addr)) b = addr;
            push_byte(addr, need_rs);
            push_byte(b, 1'b0);
          end else begin
            push_byte(8'($urandom_range(0, 255)), need_rs || $urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 3)) begin
              push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
          end
          // after a cut frame the next request restarts the buffer
          need_rs = (pick >= 78 && pick < 86);
        end
      end

      while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0) begin
        @(posedge clk);
      end
      repeat (8) @(posedge clk);
    end

    $display("run: %0d bytes over %0d address settings, %0d results checked", bytes_taken,
             NUM_PHASES, results_seen);
    $display("run: ok %0d, address %0d, function %0d, crc %0d; long hold-off %s",
             status_seen[ST_OK], status_seen[ST_ADDR_ERR], status_seen[ST_FUNC_ERR],
             status_seen[ST_CRC_ERR], hold_done ? "done" : "not reached");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* modbus_rtu_response_framer.f */
design/mrf_pkg.sv
design/mrf_front.sv
design/mrf_queue.sv
design/mrf_back.sv
design/modbus_rtu_response_framer.sv
bench/modbus_rtu_response_framer_tb.sv
